FILE: rtl/dsm_pkg.sv
// Duration statistics monitor: shared types, constants and helper functions.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dsm_pkg;

  localparam logic [29:0] NSEC_PER_SEC = 30'd1000000000;
  localparam logic [29:0] NSEC_MAX     = 30'd999999999;
  localparam logic [47:0] SUM_SEC_MAX  = 48'hFFFF_FFFF_FFFF;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 360;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_SEC  = 2'd0,
    REG_LOWER_NSEC = 2'd1,
    REG_UPPER_SEC  = 2'd2,
    REG_UPPER_NSEC = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] lower_sec;
    logic [29:0] lower_nsec;
    logic [31:0] upper_sec;
    logic [29:0] upper_nsec;
  } bounds_t;

  typedef struct packed {
    logic [31:0] last_sec;
    logic [29:0] last_nsec;
    logic [31:0] event_total;
    logic [31:0] over_total;
    logic [31:0] under_total;
    logic [31:0] min_sec;
    logic [29:0] min_nsec;
    logic [31:0] max_sec;
    logic [29:0] max_nsec;
    logic [47:0] sum_sec;
    logic [29:0] sum_nsec;
  } stats_t;

  // a < b in (seconds, nanoseconds) order
  function automatic logic time_lt(logic [31:0] as, logic [29:0] an,
                                   logic [31:0] bs, logic [29:0] bn);
    return (as < bs) || ((as == bs) && (an < bn));
  endfunction

  function automatic logic [29:0] clamp_nsec(logic [29:0] v);
    return (v > NSEC_MAX) ? NSEC_MAX : v;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (&c) ? c : c + 32'd1;
  endfunction

endpackage

FILE: rtl/dsm_duration.sv
// Duration statistics monitor: stop minus start with nanosecond borrow,
// clamped to zero when the stop precedes the start. Uses dsm_pkg.
`timescale 1ns / 1ps

module dsm_duration
  import dsm_pkg::*;
(
  input  logic [31:0] now_sec,
  input  logic [29:0] now_nsec,
  input  logic [31:0] begin_sec,
  input  logic [29:0] begin_nsec,
  output logic [31:0] dur_sec,
  output logic [29:0] dur_nsec
);

  logic        negative;
  logic        borrow;
  logic [30:0] nsec_diff;

  assign negative  = time_lt(now_sec, now_nsec, begin_sec, begin_nsec);
  assign borrow    = now_nsec < begin_nsec;
  assign nsec_diff = {1'b0, now_nsec} - {1'b0, begin_nsec}
                     + (borrow ? {1'b0, NSEC_PER_SEC} : 31'd0);

  always_comb begin
    if (negative) begin
      dur_sec  = '0;
      dur_nsec = '0;
    end else begin
      dur_sec  = now_sec - begin_sec - {31'd0, borrow};
      dur_nsec = nsec_diff[29:0];
    end
  end

endmodule

FILE: rtl/dsm_stats.sv
// Duration statistics monitor: start time and statistics registers with their
// combinational update logic. Uses dsm_pkg and dsm_duration.
`timescale 1ns / 1ps

module dsm_stats
  import dsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  op_t         op,
  input  logic [31:0] time_sec,
  input  logic [29:0] time_nsec,
  input  bounds_t     bounds,
  output stats_t      stats_next
);

  logic [31:0] begin_sec;
  logic [29:0] begin_nsec;
  logic [31:0] begin_sec_next;
  logic [29:0] begin_nsec_next;
  stats_t      stats;

  logic [31:0] dur_sec;
  logic [29:0] dur_nsec;
  logic [30:0] sum_n_raw;
  logic        sum_carry;
  logic [29:0] sum_n;
  logic [48:0] sum_s;

  dsm_duration u_duration (
    .now_sec   (time_sec),
    .now_nsec  (time_nsec),
    .begin_sec (begin_sec),
    .begin_nsec(begin_nsec),
    .dur_sec   (dur_sec),
    .dur_nsec  (dur_nsec)
  );

  assign sum_n_raw = {1'b0, stats.sum_nsec} + {1'b0, dur_nsec};
  assign sum_carry = sum_n_raw >= {1'b0, NSEC_PER_SEC};
  assign sum_n     = sum_carry ? (sum_n_raw[29:0] - NSEC_PER_SEC) : sum_n_raw[29:0];
  assign sum_s     = {1'b0, stats.sum_sec} + {17'd0, dur_sec} + {48'd0, sum_carry};

  always_comb begin
    stats_next      = stats;
    begin_sec_next  = begin_sec;
    begin_nsec_next = begin_nsec;
    case (op)
      OP_START: begin
        begin_sec_next  = time_sec;
        begin_nsec_next = time_nsec;
      end
      OP_STOP: begin
        stats_next.last_sec  = dur_sec;
        stats_next.last_nsec = dur_nsec;
        if ((stats.event_total == '0) ||
            time_lt(dur_sec, dur_nsec, stats.min_sec, stats.min_nsec)) begin
          stats_next.min_sec  = dur_sec;
          stats_next.min_nsec = dur_nsec;
        end
        stats_next.event_total = sat_inc(stats.event_total);
        if (time_lt(stats.max_sec, stats.max_nsec, dur_sec, dur_nsec)) begin
          stats_next.max_sec  = dur_sec;
          stats_next.max_nsec = dur_nsec;
        end
        if (time_lt(dur_sec, dur_nsec, bounds.lower_sec, bounds.lower_nsec)) begin
          stats_next.under_total = sat_inc(stats.under_total);
        end
        if (time_lt(bounds.upper_sec, bounds.upper_nsec, dur_sec, dur_nsec)) begin
          stats_next.over_total = sat_inc(stats.over_total);
        end
        if (sum_s[48]) begin
          stats_next.sum_sec  = SUM_SEC_MAX;
          stats_next.sum_nsec = NSEC_MAX;
        end else begin
          stats_next.sum_sec  = sum_s[47:0];
          stats_next.sum_nsec = sum_n;
        end
      end
      OP_CLEAR: begin
        stats_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_sec  <= '0;
      begin_nsec <= '0;
      stats      <= '0;
    end else if (advance) begin
      begin_sec  <= begin_sec_next;
      begin_nsec <= begin_nsec_next;
      stats      <= stats_next;
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (stats.event_total != '0) |->
      !time_lt(stats.max_sec, stats.max_nsec, stats.min_sec, stats.min_nsec))
    else $error("shortest duration exceeds longest duration");

  a_bound_counts: assert property (@(posedge clk) disable iff (rst)
    (stats.over_total <= stats.event_total) && (stats.under_total <= stats.event_total))
    else $error("bound counter exceeds event counter");

  a_nsec_range: assert property (@(posedge clk) disable iff (rst)
    (stats.sum_nsec <= NSEC_MAX) && (stats.last_nsec <= NSEC_MAX))
    else $error("nanosecond field out of range");

endmodule

FILE: rtl/duration_statistics_monitor.sv
// Duration statistics monitor top level: configuration registers, input
// register, result register and stream handshake. Uses dsm_pkg and dsm_stats.
//
//   channel   direction  payload (lowest bit first)
//   s_*       in         op[1:0], time_sec[33:2], time_nsec[63:34]
//   m_*       out        last_sec, last_nsec, event_total, over_total, under_total,
//                        min_sec, min_nsec, max_sec, max_nsec, sum_sec, sum_nsec
//   cfg_*     in         register index 0..3, 32-bit write data
//
// One transaction per cycle sustained while results are taken; an input transaction
// is captured in the input register, and its result then in the result register.
// The statistics update is a single pass between the input and result registers.
// Reset is synchronous and clears bounds, start time, statistics and valid flags.
// A stalled result holds the result register; the input register keeps accepting
// only while the result register can take the item ahead of it.
`timescale 1ns / 1ps

module duration_statistics_monitor
  import dsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // op[1:0], time_sec[33:2], time_nsec[63:34]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // last_sec[31:0], last_nsec[61:32],
                                           // event_total[93:62], over_total[125:94],
                                           // under_total[157:126], min_sec[189:158],
                                           // min_nsec[219:190], max_sec[251:220],
                                           // max_nsec[281:252], sum_sec[329:282],
                                           // sum_nsec[359:330]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bounds_t     bounds;
  logic        in_valid;
  op_t         in_op;
  logic [31:0] in_sec;
  logic [29:0] in_nsec;
  logic        advance;
  stats_t      stats_next;
  stats_t      result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOWER_SEC:  bounds.lower_sec  <= cfg_data;
        REG_LOWER_NSEC: bounds.lower_nsec <= clamp_nsec(cfg_data[29:0]);
        REG_UPPER_SEC:  bounds.upper_sec  <= cfg_data;
        REG_UPPER_NSEC: bounds.upper_nsec <= clamp_nsec(cfg_data[29:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= op_t'(s_tdata[1:0]);
      in_sec  <= s_tdata[33:2];
      in_nsec <= clamp_nsec(s_tdata[63:34]);
    end
  end

  dsm_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .op        (in_op),
    .time_sec  (in_sec),
    .time_nsec (in_nsec),
    .bounds    (bounds),
    .stats_next(stats_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= stats_next;
    end
  end

  assign m_tdata = {result.sum_nsec, result.sum_sec, result.max_nsec, result.max_sec,
                    result.min_nsec, result.min_sec, result.under_total,
                    result.over_total, result.event_total, result.last_nsec,
                    result.last_sec};

endmodule
